// ----- hw/rtl/qdd_pkg.sv -----
package qdd_pkg;

   localparam int unsigned TimeWidth     = 48;
   localparam int unsigned CountWidth    = 5;
   localparam int unsigned DetentWidth   = 4;
   localparam int unsigned DebounceWidth = 16;
   localparam int unsigned CsrDataWidth  = 16;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      CSR_DETENT_STEPS     = 1'b0,
      CSR_EDGE_DEBOUNCE_US = 1'b1
   } csr_index_type;

   localparam logic [DetentWidth-1:0]   DetentStepsReset    = 4'd2;
   localparam logic [DebounceWidth-1:0] EdgeDebounceUsReset = 16'd300;
   localparam logic [1:0]               PreviousAbReset     = 2'b11;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   // Gray transition table, indexed by {previous AB, current AB}.
   localparam step_type GRAY_STEP [16] = '{
      STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
      STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
      STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
      STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
   };

   // Decision for one sample, from the step logic to the state registers.
   typedef struct packed {
      logic                         take;
      logic signed [CountWidth-1:0] count_next;
      logic                         emit;
      logic                         up;
   } step_result_type;

endpackage

// ----- hw/rtl/qdd_step.sv -----
module qdd_step (
   input  logic [1:0]                             previous_ab,
   input  logic [1:0]                             current_ab,
   input  logic [qdd_pkg::TimeWidth-1:0]          now_us,
   input  logic [qdd_pkg::TimeWidth-1:0]          last_step_time,
   input  logic [qdd_pkg::DebounceWidth-1:0]      debounce_us,
   input  logic signed [qdd_pkg::CountWidth-1:0]  detent_count,
   input  logic [qdd_pkg::DetentWidth-1:0]        detent_steps,
   output qdd_pkg::step_result_type               result
);
   import qdd_pkg::*;

   step_type                        step;
   logic [TimeWidth:0]              elapsed;
   logic                            time_ok;
   logic signed [CountWidth-1:0]    base;
   logic signed [CountWidth:0]      sum;
   logic signed [CountWidth:0]      limit_pos;
   logic signed [CountWidth:0]      limit_neg;

   assign step = GRAY_STEP[{previous_ab, current_ab}];

   // The borrow bit of the subtraction flags time going backwards.
   assign elapsed = {1'b0, now_us} - {1'b0, last_step_time};
   assign time_ok = !elapsed[TimeWidth]
                    && (elapsed[TimeWidth-1:0] >= {{(TimeWidth-DebounceWidth){1'b0}}, debounce_us});

   // A step against the counter's sign restarts the count.
   always_comb begin
      base = detent_count;
      if ((detent_count > 0 && step == STEP_DOWN) || (detent_count < 0 && step == STEP_UP)) begin
         base = '0;
      end
   end

   assign sum       = (step == STEP_UP) ? ({base[CountWidth-1], base} + 6'sd1)
                                        : ({base[CountWidth-1], base} - 6'sd1);
   assign limit_pos = $signed({2'b00, detent_steps});
   assign limit_neg = -limit_pos;

   always_comb begin
      result.take       = (step != STEP_NONE) && time_ok;
      result.emit       = 1'b0;
      result.up         = 1'b0;
      result.count_next = sum[CountWidth-1:0];
      if (sum >= limit_pos) begin
         result.emit       = result.take;
         result.up         = 1'b1;
         result.count_next = '0;
      end else if (sum <= limit_neg) begin
         result.emit       = result.take;
         result.count_next = '0;
      end
   end

endmodule

// ----- hw/rtl/quadrature_detent_decoder_unit.sv -----
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// request  | req_valid/req_ready, req_level_a/_b, req_time_us | in
// response | rsp_valid/rsp_ready, rsp_direction_up          | out
// csr      | csr_write_en, csr_index, csr_wdata             | in
//
// A sample word is captured in an input register and decoded from there;
// a detent event, if any, is registered in the output register.
// One word per cycle is sustained while rsp_ready is high: the state update
// logic (table lookup, 48-bit debounce compare, counter add) is combinational.
// Synchronous active-high reset restores the register defaults and the state.
// A stalled response holds the decode stage, which in turn backs up req_ready.
module quadrature_detent_decoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_level_a,
   input  logic                                 req_level_b,
   input  logic [qdd_pkg::TimeWidth-1:0]        req_time_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_direction_up,
   input  logic                                 csr_write_en,
   input  qdd_pkg::csr_index_type               csr_index,
   input  logic [qdd_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import qdd_pkg::*;

   // Configuration registers.
   logic [DetentWidth-1:0]        detent_steps_ff;
   logic [DebounceWidth-1:0]      edge_debounce_us_ff;

   // Input register holding one sample word.
   logic                          in_vld_ff;
   logic [1:0]                    in_ab_ff;
   logic [TimeWidth-1:0]          in_time_ff;

   // Decoder state.
   logic [1:0]                    previous_ab_ff;
   logic signed [CountWidth-1:0]  detent_count_ff;
   logic [TimeWidth-1:0]          last_step_time_ff;

   // Output register.
   logic                          out_vld_ff;
   logic                          out_up_ff;

   logic                          advance;
   step_result_type               step;

   // The decode stage moves whenever the output register is free or draining.
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         detent_steps_ff     <= DetentStepsReset;
         edge_debounce_us_ff <= EdgeDebounceUsReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DETENT_STEPS:     detent_steps_ff     <= csr_wdata[DetentWidth-1:0];
            CSR_EDGE_DEBOUNCE_US: edge_debounce_us_ff <= csr_wdata[DebounceWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ab_ff   <= {req_level_a, req_level_b};
         in_time_ff <= req_time_us;
      end
   end

   qdd_step u_step (
      .previous_ab    (previous_ab_ff),
      .current_ab     (in_ab_ff),
      .now_us         (in_time_ff),
      .last_step_time (last_step_time_ff),
      .debounce_us    (edge_debounce_us_ff),
      .detent_count   (detent_count_ff),
      .detent_steps   (detent_steps_ff),
      .result         (step)
   );

   // The AB pair is stored for every sample; the counter and the timestamp
   // only move on a step that passes the debounce window.
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ab_ff    <= PreviousAbReset;
         detent_count_ff   <= '0;
         last_step_time_ff <= '0;
      end else if (advance) begin
         previous_ab_ff <= in_ab_ff;
         if (step.take) begin
            detent_count_ff   <= step.count_next;
            last_step_time_ff <= in_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance && step.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.emit) begin
         out_up_ff <= step.up;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_direction_up = out_up_ff;

   // A click always leaves the counter cleared.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && step.emit) |=> (detent_count_ff == '0))
      else $error("detent counter not cleared after a click");

   // The debounce timestamp only moves on an accepted step.
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && step.take) |=> (last_step_time_ff == $past(last_step_time_ff)))
      else $error("last step time changed without an accepted step");

   // A held sample word is not overwritten.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_time_ff) && $stable(in_ab_ff)))
      else $error("held sample word was overwritten");

   // A click reaches the response port in the next cycle.
   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      (advance && step.emit) |=> (rsp_valid && (rsp_direction_up == $past(step.up))))
      else $error("click did not reach the response port");

endmodule

// ----- tb/qdd_click_checker.sv -----
module qdd_click_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_level_a,
   input  logic                              req_level_b,
   input  logic [qdd_pkg::TimeWidth-1:0]     req_time_us,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_direction_up,
   input  logic                              csr_write_en,
   input  qdd_pkg::csr_index_type            csr_index,
   input  logic [qdd_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                mismatch_total,
   output int                                pending_clicks,
   output int                                click_total
);
   import qdd_pkg::*;

   logic [DetentWidth-1:0]   detent_steps_cfg;
   logic [DebounceWidth-1:0] debounce_cfg;
   logic [1:0]               last_ab;
   int                       detent_count;
   logic [TimeWidth-1:0]     last_step_time;
   bit                       expected_clicks [$];
   bit                       want_up;
   int                       mismatches;
   int                       clicks;

   // Gray position along the track is {A, A^B}; one position forward is a down step.
   function automatic step_type gray_delta(logic [1:0] prev_ab, logic [1:0] cur_ab);
      logic [1:0] prev_pos;
      logic [1:0] cur_pos;
      logic [1:0] delta;
      prev_pos = {prev_ab[1], ^prev_ab};
      cur_pos  = {cur_ab[1], ^cur_ab};
      delta    = cur_pos - prev_pos;
      case (delta)
         2'd3:    return STEP_UP;
         2'd1:    return STEP_DOWN;
         default: return STEP_NONE;
      endcase
   endfunction

   task automatic predict_click(input logic a, input logic b, input logic [TimeWidth-1:0] now);
      logic [1:0] ab;
      step_type   step;
      int         limit;
      ab      = {a, b};
      step    = gray_delta(last_ab, ab);
      limit   = int'(detent_steps_cfg);
      last_ab = ab;
      if (step == STEP_NONE) return;
      if (now < last_step_time || now - last_step_time < debounce_cfg) return;
      last_step_time = now;
      if ((detent_count > 0 && step == STEP_DOWN) || (detent_count < 0 && step == STEP_UP)) begin
         detent_count = 0;
      end
      detent_count += (step == STEP_UP) ? 1 : -1;
      if (detent_count >= limit) begin
         detent_count = 0;
         expected_clicks.push_back(1'b1);
      end else if (detent_count <= -limit) begin
         detent_count = 0;
         expected_clicks.push_back(1'b0);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t: click mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         detent_steps_cfg = DetentStepsReset;
         debounce_cfg     = EdgeDebounceUsReset;
         last_ab          = PreviousAbReset;
         detent_count     = 0;
         last_step_time   = '0;
         mismatches       = 0;
         clicks           = 0;
         expected_clicks.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DETENT_STEPS:     detent_steps_cfg = csr_wdata[DetentWidth-1:0];
               CSR_EDGE_DEBOUNCE_US: debounce_cfg     = csr_wdata[DebounceWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            clicks++;
            if (expected_clicks.size() == 0) begin
               report_mismatch($sformatf("direction_up %0b with no click expected",
                                         rsp_direction_up));
            end else begin
               want_up = expected_clicks.pop_front();
               if (rsp_direction_up !== want_up) begin
                  report_mismatch($sformatf("direction_up %0b, expected %0b",
                                            rsp_direction_up, want_up));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_click(req_level_a, req_level_b, req_time_us);
         end
      end
      mismatch_total <= mismatches;
      pending_clicks <= expected_clicks.size();
      click_total    <= clicks;
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import qdd_pkg::*;

   // Everything the block sees starts at a known value at time zero.
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic                    req_level_a      = 1'b1;
   logic                    req_level_b      = 1'b1;
   logic [TimeWidth-1:0]    req_time_us      = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic                    rsp_direction_up;
   logic                    csr_write_en     = 1'b0;
   csr_index_type           csr_index        = CSR_DETENT_STEPS;
   logic [CsrDataWidth-1:0] csr_wdata        = '0;

   int mismatch_total;
   int pending_clicks;
   int click_total;

   // Stimulus bookkeeping. The sample clock keeps moving forward over the whole
   // run; a sample that goes back in time is sent without moving it.
   logic [TimeWidth-1:0] stim_time   = '0;
   logic [1:0]           sent_ab     = PreviousAbReset;
   int                   samples_sent = 0;
   int                   live_steps   = 0;
   int                   dbnc_now     = int'(EdgeDebounceUsReset);
   bit                   send_calm    = 1'b0;
   bit                   rsp_calm     = 1'b0;

   // Register settings for the eight random phases. Phase 4 is partly and
   // phase 6 wholly drawn at run time.
   int detent_plan   [8] = '{1, 15, 0, 2, 3, 8, 1, 4};
   int debounce_plan [8] = '{0, 65535, 300, 1, 0, 1000, 0, 50};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quadrature_detent_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_direction_up (rsp_direction_up),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   qdd_click_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_direction_up (rsp_direction_up),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_total   (mismatch_total),
      .pending_clicks   (pending_clicks),
      .click_total      (click_total)
   );

   // Next AB pair when the knob turns one Gray step. Turning up walks
   // 11 -> 01 -> 00 -> 10 -> 11, and turning down walks the other way.
   function automatic logic [1:0] next_ab(logic [1:0] ab, bit up);
      case (ab)
         2'b11:   return up ? 2'b01 : 2'b10;
         2'b01:   return up ? 2'b00 : 2'b11;
         2'b00:   return up ? 2'b10 : 2'b01;
         default: return up ? 2'b11 : 2'b00;
      endcase
   endfunction

   // Offers one sample word and returns at the edge where it is taken. The
   // valid line stays high on return, so a back-to-back word never drops it;
   // an idle gap lowers it first. Only words that change exactly one line
   // count as live steps, since the block ignores the rest.
   task automatic send_sample(input logic [1:0] ab, input logic [TimeWidth-1:0] stamp);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_level_a <= ab[1];
      req_level_b <= ab[0];
      req_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      if ($countones(ab ^ sent_ab) == 1) live_steps++;
      sent_ab = ab;
   endtask

   // Drops valid and waits until every predicted click has come back. The
   // extra cycles cover samples that make no click but may still sit in the
   // two pipeline stages.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_clicks != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes both registers on back-to-back edges. The detent register
   // gets random junk above its four bits, which the block must ignore.
   task automatic configure(input int detent_val, input int dbnc_val);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DETENT_STEPS;
      csr_wdata    <= {12'($urandom()), 4'(detent_val)};
      @(posedge clock);
      csr_index    <= CSR_EDGE_DEBOUNCE_US;
      csr_wdata    <= 16'(dbnc_val);
      @(posedge clock);
      csr_write_en <= 1'b0;
      dbnc_now = dbnc_val;
   endtask

   // The receiver draws a stall before each click word, except in calm
   // stretches, where it keeps ready high.
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [TimeWidth-1:0] delta;
      logic [TimeWidth-1:0] base;
      logic [1:0]           turn_ab;
      int                   detent_val;
      int                   dbnc_val;
      int                   phase_start;
      int                   mode;
      int                   pick;
      bit                   rotate_up;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed cases under the reset settings: two Gray steps per click and
      // 300 us of debounce. A step before 300 us is dropped because the last
      // step time starts at zero; a close step and a step that goes back in
      // time are dropped too; a repeated pair and a pair where both lines
      // flip do nothing; and a reversal clears the half-built click.
      send_sample(2'b01, 48'd100);
      send_sample(2'b00, 48'd300);
      send_sample(2'b10, 48'd500);
      send_sample(2'b11, 48'd700);
      send_sample(2'b10, 48'd650);
      send_sample(2'b10, 48'd2000);
      send_sample(2'b01, 48'd3000);
      send_sample(2'b11, 48'd4000);
      send_sample(2'b01, 48'd5000);
      send_sample(2'b00, 48'd6000);

      // With a zero detent count every accepted step is a click of its own,
      // and with zero debounce a step at the same microsecond still counts.
      wait_idle();
      configure(0, 0);
      send_sample(2'b10, 48'd7000);
      send_sample(2'b11, 48'd7000);
      send_sample(2'b10, 48'd7000);

      // Largest settings: fifteen steps per click and the longest debounce.
      wait_idle();
      configure(15, 65535);
      send_sample(2'b11, 48'd8000);
      send_sample(2'b01, 48'd80000);
      stim_time = 48'd80000;

      // Random phases. Each one gets its own settings and a jump of the
      // sample clock into the next eighth of the 48-bit range, with some room
      // left above so the clock never wraps. Most words are rotations with runs
      // in one direction, some of them faster than the debounce; the rest are
      // random pairs, samples from the past and long pauses.
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         detent_val = detent_plan[p];
         dbnc_val   = debounce_plan[p];
         if (p == 4) dbnc_val = $urandom_range(0, 600);
         if (p == 6) begin
            detent_val = $urandom_range(1, 15);
            dbnc_val   = $urandom_range(0, 65535);
         end
         configure(detent_val, dbnc_val);

         base[31:0]  = $urandom();
         base[44:32] = 13'($urandom());
         if (&base[44:41]) base[41] = 1'b0;
         base[47:45] = 3'(p);
         if (base > stim_time) stim_time = base;

         send_calm   = ($urandom_range(0, 3) == 0);
         rsp_calm    = ($urandom_range(0, 3) == 0);
         rotate_up   = 1'($urandom_range(0, 1));
         phase_start = live_steps;

         while (live_steps - phase_start < 250) begin
            // Hold the sender back until the block has drained, now and then.
            if ($urandom_range(0, 199) == 0 || (p == 0 && live_steps - phase_start == 100)) begin
               wait_idle();
            end
            if ($urandom_range(0, 63) == 0) begin
               send_calm = ($urandom_range(0, 3) == 0);
               rsp_calm  = ($urandom_range(0, 3) == 0);
            end
            mode = $urandom_range(0, 99);
            if (mode < 80) begin
               if ($urandom_range(0, 15) == 0) rotate_up = !rotate_up;
               pick = $urandom_range(0, 99);
               if (pick < 12 && dbnc_now > 0) begin
                  delta = TimeWidth'($urandom_range(0, dbnc_now - 1));
               end else if (pick < 20) begin
                  delta = TimeWidth'(dbnc_now);
               end else begin
                  delta = TimeWidth'(dbnc_now + $urandom_range(1, 3000));
               end
               stim_time = stim_time + delta;
               send_sample(next_ab(sent_ab, rotate_up), stim_time);
            end else if (mode < 90) begin
               stim_time = stim_time + $urandom_range(0, 2 * dbnc_now + 10);
               send_sample(2'($urandom()), stim_time);
            end else if (mode < 95) begin
               send_sample(next_ab(sent_ab, rotate_up),
                           stim_time - $urandom_range(1, 5000));
            end else begin
               stim_time = stim_time + {16'd0, $urandom()};
               send_sample(next_ab(sent_ab, rotate_up), stim_time);
            end
         end
      end

      // Timestamp extremes: two up steps at the top of the range with one
      // step per click and no debounce, then a step and a double flip at zero,
      // both in the past.
      wait_idle();
      configure(1, 0);
      turn_ab = next_ab(sent_ab, 1'b1);
      send_sample(turn_ab, '1);
      turn_ab = next_ab(turn_ab, 1'b1);
      send_sample(turn_ab, '1);
      send_sample(next_ab(turn_ab, 1'b0), '0);
      send_sample(~sent_ab, '0);

      wait_idle();
      repeat (20) @(posedge clock);

      $display("Sent %0d sample words (%0d live Gray steps) over directed cases and 8 settings.",
               samples_sent, live_steps);
      $display("Checked %0d detent click words against the prediction.", click_total);
      if (mismatch_total == 0 && pending_clicks == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Safety net far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
